FILE: hdl/tis_pkg.sv
// Shared constants, register codes and fixed-point helpers for the terminator shading block.
// No dependencies.
package tis_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // configuration register codes
  localparam int          CFG_IDX_W = 3;
  localparam logic [2:0]  CFG_DEC   = 3'd0;
  localparam logic [2:0]  CFG_GHA   = 3'd1;
  localparam logic [2:0]  CFG_BASE  = 3'd2;
  localparam logic [2:0]  CFG_MINC  = 3'd3;
  localparam logic [2:0]  CFG_MAXG  = 3'd4;

  localparam logic [15:0] RST_DEC  = 16'd0;
  localparam logic [15:0] RST_GHA  = 16'd0;
  localparam logic [15:0] RST_BASE = 16'd2294;
  localparam logic [15:0] RST_MINC = 16'd5243;
  localparam logic [15:0] RST_MAXG = 16'd13107;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Q30 coefficients of sin(pi/2 * t)
  localparam logic [30:0] K9 = 31'd172272;
  localparam logic [30:0] HORNER_K [4] = '{31'd5026995, 31'd85569306,
                                           31'd693598669, 31'd1686629713};

  // signed Q30 product, magnitude truncated toward zero
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    p  = 62'(ma) * 62'(mb);
    r  = p[61:30];
    return (a[31] != b[31]) ? signed'(-r) : signed'(r);
  endfunction

endpackage

FILE: hdl/terminator_illumination_shade.sv
// Day/night terminator shading: daylight fraction of one map point per clock.
// Depends on tis_pkg, tis_sine and tis_div.
//
// Use: drive latitude_i/longitude_i with start high; busy is always low, so a
// point is taken on every clock edge where start is high. The illumination
// beat leaves on illumination_o, marked by done_o for one cycle, after its
// start beat has passed the sine pipelines (7), three product stages, the
// 32-stage twilight-width divider, one width stage, the FRACTION_BITS-stage
// illumination divider and the output register. One point per cycle is
// sustained.
// The receiver cannot stall: every result is shown for one cycle only.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Index 0 declination, 1 hour angle, 2 base sharpness,
// 3 minimum crossing, 4 maximum gradient; other indexes are ignored. Write
// only when no point is in flight, the pipeline reads the registers live.
// Reset (rst_ni low, asynchronous) clears all valid bits and restores the
// register defaults; no clearing pass, the block takes points at once.
module terminator_illumination_shade import tis_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [15:0]     latitude_i,
  input  logic signed [15:0]     longitude_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  output logic                   done_o,
  output logic [FRACTION_BITS:0] illumination_o
);

  localparam int LATENCY = 44 + FRACTION_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // ---------------- configuration registers ----------------
  logic [15:0] dec_q, gha_q, base_q, minc_q, maxg_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q  <= RST_DEC;
      gha_q  <= RST_GHA;
      base_q <= RST_BASE;
      minc_q <= RST_MINC;
      maxg_q <= RST_MAXG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEC:  dec_q  <= cfg_data_i;
        CFG_GHA:  gha_q  <= cfg_data_i;
        CFG_BASE: base_q <= cfg_data_i;
        CFG_MINC: minc_q <= cfg_data_i;
        CFG_MAXG: maxg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // fraction register to Q30; zero acts as one LSB, capped at 2.0
  function automatic logic [31:0] frac_q30(input logic [15:0] v);
    logic [39:0] f;
    f = 40'((v == 16'd0) ? 16'd1 : v) << (30 - FRACTION_BITS);
    if (f > 40'h80000000) f = 40'h80000000;
    return f[31:0];
  endfunction

  logic [31:0] base_f, minc_f, maxg_f;
  assign base_f = frac_q30(base_q);
  assign minc_f = frac_q30(minc_q);
  assign maxg_f = frac_q30(maxg_q);

  // ---------------- angles and sines ----------------
  logic signed [31:0] lat_x, lon_x, dec_x;
  logic [31:0]        gha_x;
  logic [ANGLE_BITS-1:0] lat_a, dec_a, ha_a;

  assign lat_x = 32'(latitude_i);
  assign lon_x = 32'(longitude_i);
  assign dec_x = 32'(signed'(dec_q));
  assign gha_x = 32'(gha_q);
  assign lat_a = lat_x[ANGLE_BITS-1:0];
  assign dec_a = dec_x[ANGLE_BITS-1:0];
  assign ha_a  = lon_x[ANGLE_BITS-1:0] + gha_x[ANGLE_BITS-1:0];

  logic               accept;
  logic [4:0]         s_vld;
  logic signed [31:0] sin_lat, cos_lat, sin_dec, cos_dec, cos_ha;

  assign accept = start && !busy;

  tis_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_lat (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(lat_a),
    .valid_o(s_vld[0]), .sine_o(sin_lat));
  tis_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_lat (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(lat_a + QUARTER),
    .valid_o(s_vld[1]), .sine_o(cos_lat));
  tis_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_dec (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(dec_a),
    .valid_o(s_vld[2]), .sine_o(sin_dec));
  tis_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_dec (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(dec_a + QUARTER),
    .valid_o(s_vld[3]), .sine_o(cos_dec));
  tis_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ha (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(ha_a + QUARTER),
    .valid_o(s_vld[4]), .sine_o(cos_ha));

  // ---------------- products ----------------
  // M1: cos(lat)cos(dec) and sin(lat)sin(dec)
  logic signed [31:0] ld_q, sd_q, ch_q;
  logic               m1_v_q;
  // M2: hour-angle term, crossing with lower clamp
  logic signed [31:0] ldh_q, sd2_q;
  logic [31:0]        cross_q;
  logic               m2_v_q;
  // M3: cosz and width divider overflow check
  logic signed [32:0] cosz_q;
  logic [31:0]        cross3_q;
  logic               ovf_q;
  logic               m3_v_q;

  logic [31:0] ld_mag;
  assign ld_mag = ld_q[31] ? 32'(-ld_q) : 32'(ld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else begin
      m1_v_q <= &s_vld;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q     <= mul_q30(cos_lat, cos_dec);
    sd_q     <= mul_q30(sin_lat, sin_dec);
    ch_q     <= cos_ha;
    ldh_q    <= mul_q30(ld_q, ch_q);
    sd2_q    <= sd_q;
    cross_q  <= (ld_mag < minc_f) ? minc_f : ld_mag;
    cosz_q   <= 33'(sd2_q) + 33'(ldh_q);
    cross3_q <= cross_q;
    // quotient would need more than 32 bits: width is capped anyway
    ovf_q    <= 34'(base_f) >= (34'(cross_q) << 2);
  end

  // ---------------- twilight half-width g = base / crossing ----------------
  logic        gd_v;
  logic [31:0] gd_q;
  logic [33:0] gd_side;

  tis_div #(.DW(32), .QB(32), .SW(34)) u_gdiv (
    .clk_i, .rst_ni,
    .valid_i(m3_v_q),
    .rem_i(ovf_q ? 32'd0 : (base_f >> 2)),
    .low_i({base_f[1:0], 30'd0}),
    .div_i(cross3_q),
    .side_i({ovf_q, cosz_q}),
    .valid_o(gd_v),
    .quot_o(gd_q),
    .side_o(gd_side));

  logic [31:0]        g_d;
  logic [31:0]        g_q;
  logic signed [33:0] num_q;
  logic               gs_v_q;

  assign g_d = (gd_side[33] || (gd_q > maxg_f)) ? maxg_f : gd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gs_v_q <= 1'b0;
    else         gs_v_q <= gd_v;
  end
  always_ff @(posedge clk_i) begin
    g_q   <= g_d;
    num_q <= 34'(signed'(gd_side[32:0])) + signed'(34'(g_d));
  end

  // ---------------- illumination = num / 2g ----------------
  logic [32:0] twog;
  logic        pos, sat;

  assign twog = {g_q, 1'b0};
  assign pos  = num_q > 34'sd0;
  assign sat  = num_q >= signed'(34'(twog));

  logic                     id_v;
  logic [FRACTION_BITS-1:0] id_q;
  logic [1:0]               id_side;

  tis_div #(.DW(33), .QB(FRACTION_BITS), .SW(2)) u_idiv (
    .clk_i, .rst_ni,
    .valid_i(gs_v_q),
    .rem_i((pos && !sat) ? num_q[32:0] : 33'd0),
    .low_i('0),
    .div_i(twog),
    .side_i({pos, sat}),
    .valid_o(id_v),
    .quot_o(id_q),
    .side_o(id_side));

  logic                   done_q;
  logic [FRACTION_BITS:0] ill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= id_v;
  end
  always_ff @(posedge clk_i) begin
    // night side gives zero, at or past full width saturates to one
    if (!id_side[1])     ill_q <= '0;
    else if (id_side[0]) ill_q <= {1'b1, {FRACTION_BITS{1'b0}}};
    else                 ill_q <= {1'b0, id_q};
  end

  assign done_o         = done_q;
  assign illumination_o = ill_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result beat missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result beat without matching start beat");

  a_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_v_q |-> (g_q != 32'd0))
    else $error("twilight width is zero at illumination divider");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (illumination_o <= {1'b1, {FRACTION_BITS{1'b0}}}))
    else $error("illumination above full daylight");

endmodule

FILE: hdl/tis_sine.sv
// Pipelined sine of a binary angle: quadrant fold and degree-9 odd polynomial, Q30 out.
// Depends on tis_pkg. Seven register stages.
module tis_sine import tis_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  valid_o,
  output logic signed [31:0]    sine_o
);

  logic [1:0]  quad;
  logic [30:0] t_raw;
  logic [30:0] t0_d;
  logic [30:0] t0_q;
  logic        neg0_q;
  logic        v0_q;

  assign quad  = angle_i[ANGLE_BITS-1 -: 2];
  assign t_raw = 31'(angle_i[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
  assign t0_d  = quad[0] ? (ONE_Q30 - t_raw) : t_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    t0_q   <= t0_d;
    neg0_q <= quad[1];
  end

  // t squared
  logic [61:0] sq;
  logic [30:0] t2_q;
  logic [30:0] t1_q;
  logic        neg1_q;
  logic        v1_q;

  assign sq = 62'(t0_q) * 62'(t0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    t2_q   <= sq[60:30];
    t1_q   <= t0_q;
    neg1_q <= neg0_q;
  end

  // Horner steps, one per stage
  logic [30:0] p_q   [4];
  logic [30:0] t_q   [4];
  logic [30:0] t2k_q [4];
  logic        neg_q [4];
  logic        v_q   [4];

  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic [30:0] p_in;
    logic [30:0] t_in;
    logic [30:0] t2_in;
    logic        neg_in;
    logic        v_in;
    logic [61:0] hp;
    if (j == 0) begin : g_first
      assign p_in   = K9;
      assign t_in   = t1_q;
      assign t2_in  = t2_q;
      assign neg_in = neg1_q;
      assign v_in   = v1_q;
    end else begin : g_next
      assign p_in   = p_q[j-1];
      assign t_in   = t_q[j-1];
      assign t2_in  = t2k_q[j-1];
      assign neg_in = neg_q[j-1];
      assign v_in   = v_q[j-1];
    end
    assign hp = 62'(t2_in) * 62'(p_in);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[j] <= 1'b0;
      else         v_q[j] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      p_q[j]   <= HORNER_K[j] - hp[60:30];
      t_q[j]   <= t_in;
      t2k_q[j] <= t2_in;
      neg_q[j] <= neg_in;
    end
  end

  // final odd factor, clamp and sign
  logic [61:0] fp;
  logic [31:0] r;
  logic [31:0] rc;
  logic signed [31:0] sine_q;
  logic        vo_q;

  assign fp = 62'(t_q[3]) * 62'(p_q[3]);
  assign r  = fp[61:30];
  assign rc = (r > 32'(ONE_Q30)) ? 32'(ONE_Q30) : r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= v_q[3];
  end
  always_ff @(posedge clk_i) begin
    sine_q <= neg_q[3] ? signed'(-rc) : signed'(rc);
  end

  assign valid_o = vo_q;
  assign sine_o  = sine_q;

endmodule

FILE: hdl/tis_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a carried sideband.
// No dependencies. Remainder in must be below the divisor.
module tis_div #(
  parameter int DW = 32,
  parameter int QB = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QB-1:0] low_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] low_q  [QB];
  logic [QB-1:0] quot_q [QB];
  logic [DW-1:0] div_q  [QB];
  logic [SW-1:0] side_q [QB];
  logic          v_q    [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [QB-1:0] quot_in;
    logic [DW-1:0] div_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   r;
    logic [DW:0]   rs;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in  = rem_i;
      assign low_in  = low_i;
      assign quot_in = '0;
      assign div_in  = div_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign low_in  = low_q[i-1];
      assign quot_in = quot_q[i-1];
      assign div_in  = div_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end
    assign r  = {rem_in, low_in[QB-1]};
    assign ge = (r >= {1'b0, div_in});
    assign rs = r - {1'b0, div_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i] <= 1'b0;
      else         v_q[i] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? rs[DW-1:0] : r[DW-1:0];
      low_q[i]  <= low_in << 1;
      quot_q[i] <= {quot_in[QB-2:0], ge};
      div_q[i]  <= div_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = quot_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule
